// ===== rtl/indexed_ordered_list_unit_assert.svh =====
// Assertion helpers for the list unit RTL, included by iol_ctrl.
`ifndef INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH
`define INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define IOL_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define IOL_ASSERT(lbl, prop, msg) \
  `IOL_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define IOL_ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define IOL_ASSERT(lbl, prop, msg)

`endif

`endif

// ===== rtl/iol_pkg.sv =====
`default_nettype none

package iol_pkg;

  // List depth and derived widths
  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Beat field widths
  localparam int MODE_W  = 2;
  localparam int POS_W   = 5;
  localparam int DST_W   = 4;
  localparam int WORD_W  = 64;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Compare width wide enough for positions and the entry count
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_MOVE   = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2,
    CELL_LOAD  = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e [DEPTH-1:0] cmd;
    logic [WORD_W-1:0]     load_word;
  } cell_ctrl_t;

  typedef struct packed {
    status_e              status;
    logic [WORD_W-1:0]    read_value;
    logic [COUNT_W-1:0]   entry_count;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/iol_if.sv =====
`default_nettype none

interface iol_req_if import iol_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  logic [DST_W-1:0]  dest_position;
  logic [WORD_W-1:0] value;

  modport source (output valid, mode, position, dest_position, value, input ready);
  modport sink   (input valid, mode, position, dest_position, value, output ready);
endinterface

interface iol_rsp_if import iol_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [WORD_W-1:0]  read_value;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/iol_cell.sv =====
`default_nettype none

module iol_cell import iol_pkg::*; (
  input  wire logic              clk_i,
  input  wire cell_cmd_e         cmd_i,
  input  wire logic [WORD_W-1:0] left_i,
  input  wire logic [WORD_W-1:0] right_i,
  input  wire logic [WORD_W-1:0] load_i,
  output logic [WORD_W-1:0]      q_o
);

  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] word_d;

  always_comb begin
    case (cmd_i)
      CELL_LEFT:  word_d = left_i;
      CELL_RIGHT: word_d = right_i;
      CELL_LOAD:  word_d = load_i;
      default:    word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign q_o = word_q;

endmodule

`default_nettype wire

// ===== rtl/iol_ctrl.sv =====
`default_nettype none
`include "indexed_ordered_list_unit_assert.svh"

module iol_ctrl import iol_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [DST_W-1:0]  dest_position_i,
  input  wire logic [WORD_W-1:0] value_i,
  input  wire logic [WORD_W-1:0] pick_i,
  output cell_ctrl_t             cell_ctrl_o,
  output result_t                result_o
);

  logic [CNT_W-1:0] len_q;
  logic [CNT_W-1:0] len_d;
  logic [CNT_W-1:0] len_op;
  status_e          status;
  logic [WORD_W-1:0] rd_word;
  logic [CMP_W-1:0] len_e;
  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] dst_e;
  logic [DEPTH-1:0] load_vec;

  assign len_e = CMP_W'(len_q);
  assign pos_e = CMP_W'(position_i);
  assign dst_e = CMP_W'(dest_position_i);

  always_comb begin
    logic [CMP_W-1:0] ie;
    ie                    = '0;
    status                = ST_OK;
    len_op                = len_q;
    rd_word               = '0;
    cell_ctrl_o.load_word = value_i;
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl_o.cmd[i] = CELL_HOLD;
    end
    case (mode_e'(mode_i))
      MODE_INSERT: begin
        if (pos_e > len_e) begin
          status = ST_RANGE;
        end else if (len_q == CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          len_op = len_q + 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            ie = CMP_W'(i);
            if (ie == pos_e) begin
              cell_ctrl_o.cmd[i] = CELL_LOAD;
            end else if (ie > pos_e && ie <= len_e) begin
              cell_ctrl_o.cmd[i] = CELL_LEFT;
            end
          end
        end
      end
      MODE_DELETE: begin
        if (pos_e >= len_e) begin
          status = ST_RANGE;
        end else begin
          len_op = len_q - 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            ie = CMP_W'(i);
            if (ie >= pos_e && (ie + 1'b1) < len_e) begin
              cell_ctrl_o.cmd[i] = CELL_RIGHT;
            end
          end
        end
      end
      MODE_MOVE: begin
        if (pos_e >= len_e || dst_e >= len_e) begin
          status = ST_RANGE;
        end else begin
          // the picked entry drops into the destination, the span between shifts
          cell_ctrl_o.load_word = pick_i;
          for (int i = 0; i < DEPTH; i++) begin
            ie = CMP_W'(i);
            if (pos_e > dst_e) begin
              if (ie == dst_e) begin
                cell_ctrl_o.cmd[i] = CELL_LOAD;
              end else if (ie > dst_e && ie <= pos_e) begin
                cell_ctrl_o.cmd[i] = CELL_LEFT;
              end
            end else if (dst_e > pos_e) begin
              if (ie == dst_e) begin
                cell_ctrl_o.cmd[i] = CELL_LOAD;
              end else if (ie >= pos_e && ie < dst_e) begin
                cell_ctrl_o.cmd[i] = CELL_RIGHT;
              end
            end
          end
        end
      end
      MODE_READ: begin
        if (pos_e >= len_e) begin
          status = ST_RANGE;
        end else begin
          rd_word = pick_i;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    // cells only move on an accepted beat
    if (!fire_i) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_ctrl_o.cmd[i] = CELL_HOLD;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      load_vec[i] = (cell_ctrl_o.cmd[i] == CELL_LOAD);
    end
  end

  assign len_d = fire_i ? len_op : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign result_o.status      = status;
  assign result_o.read_value  = rd_word;
  assign result_o.entry_count = COUNT_W'(len_op);

  `IOL_ASSERT(a_len_bound, len_q <= CNT_W'(DEPTH), "entry count above depth")
  `IOL_ASSERT(a_refused_holds, (fire_i && status != ST_OK) |=> $stable(len_q), "refused op changed length")
  `IOL_ASSERT(a_insert_grows, (fire_i && mode_i == MODE_INSERT && status == ST_OK) |=> (len_q == CNT_W'($past(len_q) + 1'b1)), "insert did not grow list")
  `IOL_ASSERT(a_single_load, $onehot0(load_vec), "more than one cell loads")
  `IOL_ASSERT(a_idle_hold, (!fire_i) |=> $stable(len_q), "length moved without a beat")

endmodule

`default_nettype wire

// ===== rtl/indexed_ordered_list_unit.sv =====
// Channel  Dir  Payload                                     Handshake
// req_i    in   mode, position, dest_position, value         valid/ready
// rsp_o    out  status, read_value, entry_count              valid/ready
//
// Each beat is decoded combinationally and applied to the cell row on acceptance; the
// result is captured in the output register when the beat is accepted.
// Unstalled rate is one beat per cycle: every cell shifts, loads or holds in parallel.
// A stalled result holds the output register and drops req_i.ready until taken.
// Reset empties the list and clears the output valid; cell contents are undefined.
`default_nettype none

module indexed_ordered_list_unit import iol_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iol_req_if.sink    req_i,
  iol_rsp_if.source  rsp_o
);

  logic [WORD_W-1:0] cell_q     [DEPTH];
  logic [WORD_W-1:0] left_w     [DEPTH];
  logic [WORD_W-1:0] right_w    [DEPTH];
  logic [WORD_W-1:0] pick_word;
  cell_ctrl_t        cell_ctrl;
  result_t           result;
  logic              fire;
  logic              rsp_valid_q;
  result_t           rsp_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  assign pick_word = cell_q[IDX_W'(req_i.position)];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      left_w[i]  = (i == 0) ? '0 : cell_q[(i == 0) ? 0 : i - 1];
      right_w[i] = (i == DEPTH - 1) ? '0 : cell_q[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  iol_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .mode_i          (req_i.mode),
    .position_i      (req_i.position),
    .dest_position_i (req_i.dest_position),
    .value_i         (req_i.value),
    .pick_i          (pick_word),
    .cell_ctrl_o     (cell_ctrl),
    .result_o        (result)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    iol_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_ctrl.cmd[g]),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .load_i  (cell_ctrl.load_word),
      .q_o     (cell_q[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= result;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.read_value  = rsp_q.read_value;
  assign rsp_o.entry_count = rsp_q.entry_count;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
  import iol_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;

  logic clk_i;
  logic rst_ni;

  iol_req_if req_if ();
  iol_rsp_if rsp_if ();

  indexed_ordered_list_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the list, updated when a request beat is accepted
  logic [WORD_W-1:0] list_words [DEPTH];
  int                list_len = 0;
  result_t           expected_results [$];

  int fail_count   = 0;
  int cycle_count  = 0;
  int hold_cycles  = 0;
  bit send_gaps_on = 1'b1;
  bit recv_stalls_on = 1'b1;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[indexed_ordered_list_unit] ERROR");
      $finish;
    end
  end

  function automatic result_t apply_list_op(mode_e op, logic [POS_W-1:0] pos,
                                            logic [DST_W-1:0] dst, logic [WORD_W-1:0] word);
    result_t           r;
    logic [WORD_W-1:0] moved;
    int                i;
    r.status     = ST_OK;
    r.read_value = '0;
    case (op)
      MODE_INSERT: begin
        if (pos > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = word;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = pos; i < list_len - 1; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      MODE_MOVE: begin
        if (pos >= list_len || dst >= list_len) begin
          r.status = ST_RANGE;
        end else if (pos > dst) begin
          moved = list_words[pos];
          for (i = pos; i > dst; i--) list_words[i] = list_words[i-1];
          list_words[dst] = moved;
        end else if (dst > pos) begin
          moved = list_words[pos];
          for (i = pos; i < dst; i++) list_words[i] = list_words[i+1];
          list_words[dst] = moved;
        end
      end
      default: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.read_value = list_words[pos];
      end
    endcase
    r.entry_count = COUNT_W'(list_len);
    return r;
  endfunction

  always @(posedge clk_i) begin : beat_monitor
    result_t want;
    if (rst_ni) begin
      // predict first so a same-edge result still finds its entry
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(apply_list_op(mode_e'(req_if.mode), req_if.position,
                                                 req_if.dest_position, req_if.value));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: status %0d value %h count %0d",
                     rsp_if.status, rsp_if.read_value, rsp_if.entry_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.status !== want.status || rsp_if.read_value !== want.read_value ||
              rsp_if.entry_count !== want.entry_count) begin
            if (fail_count < 10)
              $display("mismatch: expected status %0d value %h count %0d, got %0d %h %0d",
                       want.status, want.read_value, want.entry_count,
                       rsp_if.status, rsp_if.read_value, rsp_if.entry_count);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side: random stall bursts, or a long hold when requested
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (recv_stalls_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(mode_e op, logic [POS_W-1:0] pos, logic [DST_W-1:0] dst,
                           logic [WORD_W-1:0] word);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= op;
    req_if.position      <= pos;
    req_if.dest_position <= dst;
    req_if.value         <= word;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_op(bit filling);
    mode_e             op;
    logic [POS_W-1:0]  pos;
    logic [DST_W-1:0]  dst;
    int                pick;
    int                last;
    int                ins_w;
    int                del_w;
    last  = (list_len > 0) ? list_len - 1 : 0;
    ins_w = filling ? 55 : 12;
    del_w = filling ? 10 : 50;
    dst   = DST_W'($urandom_range(0, 15));
    pick  = $urandom_range(0, 99);
    if (pick < 8) begin
      op  = mode_e'($urandom_range(0, 3));
      pos = POS_W'($urandom_range(0, 31));
    end else if (pick < 12) begin
      // just at or past the end of the list
      op  = mode_e'($urandom_range(0, 3));
      pos = POS_W'(list_len + $urandom_range(0, 1));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < ins_w) begin
        op  = MODE_INSERT;
        pos = POS_W'($urandom_range(0, list_len));
      end else if (pick < ins_w + del_w) begin
        op  = MODE_DELETE;
        pos = POS_W'($urandom_range(0, last));
      end else if (pick < ins_w + del_w + 20) begin
        op  = MODE_MOVE;
        pos = POS_W'($urandom_range(0, last));
        dst = DST_W'($urandom_range(0, last));
      end else begin
        op  = MODE_READ;
        pos = POS_W'($urandom_range(0, last));
      end
    end
    send_beat(op, pos, dst, rand_word());
  endtask

  task automatic test_edge_cases();
    // empty list refuses everything
    send_beat(MODE_READ,   0,  0, '0);
    send_beat(MODE_DELETE, 0,  0, '0);
    send_beat(MODE_MOVE,   0,  0, '0);
    send_beat(MODE_INSERT, 1,  0, rand_word());
    send_beat(MODE_INSERT, 31, 15, '1);
    // build five entries: front, end and middle inserts
    send_beat(MODE_INSERT, 0,  0, '1);
    send_beat(MODE_INSERT, 1,  0, '0);
    send_beat(MODE_INSERT, 0,  0, 64'h5555_5555_5555_5555);
    send_beat(MODE_INSERT, 3,  0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(MODE_INSERT, 2,  0, rand_word());
    send_beat(MODE_READ,   4,  0, '0);
    send_beat(MODE_READ,   5,  0, '0);
    send_beat(MODE_READ,   0,  0, '0);
    send_beat(MODE_MOVE,   0,  4, '0);
    send_beat(MODE_MOVE,   4,  0, '0);
    send_beat(MODE_MOVE,   2,  2, '0);
    send_beat(MODE_MOVE,   1,  15, '0);
    send_beat(MODE_MOVE,   16, 1, '0);
    send_beat(MODE_DELETE, 4,  0, '0);
    send_beat(MODE_DELETE, 0,  0, '0);
    send_beat(MODE_DELETE, 31, 0, '0);
    send_beat(MODE_READ,   2,  0, '0);
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH)
      send_beat(MODE_INSERT, POS_W'($urandom_range(0, list_len)), 0, rand_word());
    // position check comes before the full check
    send_beat(MODE_INSERT, 0,  0, rand_word());
    send_beat(MODE_INSERT, 16, 0, rand_word());
    send_beat(MODE_INSERT, 17, 0, rand_word());
    send_beat(MODE_MOVE,   15, 0, '0);
    send_beat(MODE_MOVE,   0,  15, '0);
    send_beat(MODE_MOVE,   7,  7, '0);
    send_beat(MODE_READ,   15, 0, '0);
    send_beat(MODE_READ,   16, 0, '0);
    send_beat(MODE_DELETE, 15, 0, '0);
    send_beat(MODE_INSERT, 15, 0, rand_word());
    while (list_len > 0)
      send_beat(MODE_DELETE, POS_W'($urandom_range(0, list_len - 1)), 0, '0);
    send_beat(MODE_READ, 0, 0, '0);
  endtask

  task automatic test_random_ops(int count);
    bit filling;
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        send_gaps_on   = ($urandom_range(0, 3) != 0);
        recv_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (n % 400 == 399) wait_drained();
      if (list_len >= DEPTH) filling = 1'b0;
      else if (list_len == 0) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = !filling;
      random_op(filling);
    end
  endtask

  task automatic test_output_hold();
    send_gaps_on = 1'b0;
    hold_cycles  = HOLD_CYCLES;
    repeat (40) random_op(1'($urandom_range(0, 1)));
    send_gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (30) random_op(1'b1);
    wait_drained();
    repeat (30) random_op(1'b0);
  endtask

  task automatic test_full_rate();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    repeat (150) random_op(list_len < DEPTH / 2);
  endtask

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.mode          = MODE_INSERT;
    req_if.position      = '0;
    req_if.dest_position = '0;
    req_if.value         = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_edge_cases();
    test_full_list();
    test_random_ops(1450);
    test_output_hold();
    test_sender_pause();
    test_full_rate();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[indexed_ordered_list_unit] OK");
    end else begin
      $display("[indexed_ordered_list_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
